[hw/rtl/vec3_arithmetic_unit_defines.svh]
// ----------------------------------------------------------------------------
// vec3_arithmetic_unit_defines.svh
// Assertion macros for the vector ALU checker.
// ----------------------------------------------------------------------------
`ifndef VEC3_ARITHMETIC_UNIT_DEFINES_SVH
`define VEC3_ARITHMETIC_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define VAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vector ALU assertion failed");

// Checked on every edge, reset included.
`define VAU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vector ALU assertion failed during reset");

`endif

[hw/rtl/vau_pkg.sv]
// ----------------------------------------------------------------------------
// vau_pkg
// Types, operation codes and helpers for the three-component vector ALU.
// ----------------------------------------------------------------------------
package vau_pkg;

  // Fraction bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_MAX      = 24;
  // Normalize quotient never exceeds 1.0, so it needs FRAC_BITS + 1 bits
  localparam int QUO_W         = FRAC_MAX + 1;
  // One square root digit per stage
  localparam int SQ_STEPS      = 32;

  // Operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DOT   = 3'd3;
  localparam logic [2:0] OP_CROSS = 3'd4;
  localparam logic [2:0] OP_LEN   = 3'd5;
  localparam logic [2:0] OP_NORM  = 3'd6;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } vau_in_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_out;
    logic               overflow;
  } vau_out_t;

  // Item in the square root stages
  typedef struct packed {
    logic [2:0]       op;
    logic [2:0][31:0] v;     // result vector, or a for length/normalize
    logic [31:0]      sc;
    logic             ovf;
    logic [63:0]      rad;   // radicand, consumed two bits per stage
    logic [33:0]      rem;
    logic [31:0]      root;
  } vau_sq_t;

  // Item in the divide stages
  typedef struct packed {
    logic [2:0]             op;
    logic [2:0][31:0]       v;
    logic [31:0]            sc;
    logic                   ovf;
    logic [31:0]            len;
    logic [2:0][33:0]       rem;
    logic [2:0][QUO_W-1:0]  quo;
  } vau_dv_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } vau_sat_t;

  // Clamp to the signed 32-bit range
  function automatic vau_sat_t sat32(input logic signed [63:0] v);
    vau_sat_t s;
    if (v > SAT_MAX) begin
      s.ovf = 1'b1;
      s.val = 32'h7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      s.ovf = 1'b1;
      s.val = 32'h8000_0000;
    end else begin
      s.ovf = 1'b0;
      s.val = v[31:0];
    end
    return s;
  endfunction

endpackage

[hw/rtl/vec3_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// vec3_arithmetic_unit
// Pipelined three-component vector ALU in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls; returns one result item
// per item, in order. Q16.16 at the default FRAC_BITS. The pipe has two stages
// of multiply and combine, 32 square root stages (one root bit each),
// FRAC_BITS + 1 divide stages (one normalize quotient bit each) and the output
// register. The pipe advances as one and holds only while an output waits.
module vec3_arithmetic_unit #(
  parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vau_pkg::vau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vau_pkg::vau_out_t out_data
);

  localparam int DV_STEPS = FRAC_BITS + 1;

  logic                    adv;
  logic                    sq_v [vau_pkg::SQ_STEPS+1];
  vau_pkg::vau_sq_t        sq_d [vau_pkg::SQ_STEPS+1];
  logic                    dv_v [DV_STEPS+1];
  vau_pkg::vau_dv_t        dv_d [DV_STEPS+1];
  vau_pkg::vau_sq_t        sq_last;
  vau_pkg::vau_dv_t        fin;
  logic [31:0]             qq;
  logic                    out_v_r;
  vau_pkg::vau_out_t       out_r;
  vau_pkg::vau_out_t       out_nxt;

  // Global advance: the pipe moves unless the output holds a waiting item
  assign adv      = !out_v_r || out_ready;
  assign in_ready = adv;

  vau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .out_valid(sq_v[0]),
    .out_data (sq_d[0])
  );

  // Square root chain
  for (genvar k = 0; k < vau_pkg::SQ_STEPS; k++) begin : g_sqrt
    vau_sqrt_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (sq_v[k]),
      .in_data  (sq_d[k]),
      .out_valid(sq_v[k+1]),
      .out_data (sq_d[k+1])
    );
  end

  // Divide setup: dividend is |a_i|, divisor the root
  assign sq_last = sq_d[vau_pkg::SQ_STEPS];
  always_comb begin
    dv_d[0]     = '0;
    dv_d[0].op  = sq_last.op;
    dv_d[0].v   = sq_last.v;
    dv_d[0].sc  = sq_last.sc;
    dv_d[0].ovf = sq_last.ovf;
    dv_d[0].len = sq_last.root;
    for (int i = 0; i < 3; i++) begin
      dv_d[0].rem[i] = sq_last.v[i][31] ? {2'b00, ~sq_last.v[i] + 32'd1}
                                        : {2'b00, sq_last.v[i]};
      if (sq_last.v[i] == 32'h8000_0000) begin
        dv_d[0].rem[i] = 34'h0_8000_0000;
      end
    end
  end
  assign dv_v[0] = sq_v[vau_pkg::SQ_STEPS];

  // Divide chain
  for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
    vau_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (dv_v[k]),
      .in_data  (dv_d[k]),
      .out_valid(dv_v[k+1]),
      .out_data (dv_d[k+1])
    );
  end

  // Final result select
  assign fin = dv_d[DV_STEPS];
  always_comb begin
    qq                 = '0;
    out_nxt.r_x        = fin.v[0];
    out_nxt.r_y        = fin.v[1];
    out_nxt.r_z        = fin.v[2];
    out_nxt.scalar_out = fin.sc;
    out_nxt.overflow   = fin.ovf;
    case (fin.op)
      vau_pkg::OP_LEN: begin
        out_nxt.r_x        = '0;
        out_nxt.r_y        = '0;
        out_nxt.r_z        = '0;
        out_nxt.overflow   = fin.len[31];
        out_nxt.scalar_out = fin.len[31] ? 32'h7FFF_FFFF : fin.len;
      end
      vau_pkg::OP_NORM: begin
        out_nxt.scalar_out = '0;
        out_nxt.overflow   = 1'b0;
        // zero length returns a unchanged
        if (fin.len != '0) begin
          qq          = 32'(fin.quo[0]);
          out_nxt.r_x = fin.v[0][31] ? (~qq + 32'd1) : qq;
          qq          = 32'(fin.quo[1]);
          out_nxt.r_y = fin.v[1][31] ? (~qq + 32'd1) : qq;
          qq          = 32'(fin.quo[2]);
          out_nxt.r_z = fin.v[2][31] ? (~qq + 32'd1) : qq;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v[DV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/vau_front.sv]
// ----------------------------------------------------------------------------
// vau_front
// Two stages: operand select, multiply and add/subtract, then shift, sum and saturate.
// ----------------------------------------------------------------------------
module vau_front #(
  parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  vau_pkg::vau_in_t in_data,
  output logic             out_valid,
  output vau_pkg::vau_sq_t out_data
);

  logic                     s1_v_r;
  logic [2:0]               op_r;
  logic [2:0][31:0]         a_r;
  logic signed [63:0]       p_r   [6];
  logic signed [63:0]       p_nxt [6];
  logic signed [32:0]       as_r  [3];
  logic signed [32:0]       as_nxt[3];
  logic signed [31:0]       ma [6];
  logic signed [31:0]       mb [6];
  logic signed [31:0]       av [3];
  logic signed [31:0]       bv [3];
  logic                     s2_v_r;
  vau_pkg::vau_sq_t         s2_r;
  vau_pkg::vau_sq_t         s2_nxt;
  logic signed [63:0]       sh [6];
  vau_pkg::vau_sat_t        st [3];
  vau_pkg::vau_sat_t        sd;

  assign av[0] = in_data.a_x;
  assign av[1] = in_data.a_y;
  assign av[2] = in_data.a_z;
  assign bv[0] = in_data.b_x;
  assign bv[1] = in_data.b_y;
  assign bv[2] = in_data.b_z;

  // Operand routing to the six multipliers
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (in_data.operation)
      vau_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = av[i];
          mb[i] = in_data.scale_factor;
        end
      end
      vau_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = av[i];
          mb[i] = bv[i];
        end
      end
      vau_pkg::OP_CROSS: begin
        ma[0] = av[1]; mb[0] = bv[2];
        ma[1] = av[2]; mb[1] = bv[1];
        ma[2] = av[2]; mb[2] = bv[0];
        ma[3] = av[0]; mb[3] = bv[2];
        ma[4] = av[0]; mb[4] = bv[1];
        ma[5] = av[1]; mb[5] = bv[0];
      end
      vau_pkg::OP_LEN, vau_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = av[i];
          mb[i] = av[i];
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 6; i++) p_nxt[i] = ma[i] * mb[i];
    for (int i = 0; i < 3; i++) begin
      if (in_data.operation == vau_pkg::OP_SUB) begin
        as_nxt[i] = 33'(av[i]) - 33'(bv[i]);
      end else begin
        as_nxt[i] = 33'(av[i]) + 33'(bv[i]);
      end
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r <= in_data.operation;
      for (int i = 0; i < 3; i++) begin
        a_r[i]  <= av[i];
        as_r[i] <= as_nxt[i];
      end
      for (int i = 0; i < 6; i++) p_r[i] <= p_nxt[i];
    end
  end

  // Stage 2: scale products, combine, saturate
  always_comb begin
    for (int i = 0; i < 6; i++) sh[i] = p_r[i] >>> FRAC_BITS;
    for (int i = 0; i < 3; i++) st[i] = '0;
    sd            = '0;
    s2_nxt        = '0;
    s2_nxt.op     = op_r;
    case (op_r)
      vau_pkg::OP_ADD, vau_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) st[i] = vau_pkg::sat32(64'(as_r[i]));
      end
      vau_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) st[i] = vau_pkg::sat32(sh[i]);
      end
      vau_pkg::OP_DOT: begin
        sd = vau_pkg::sat32(sh[0] + sh[1] + sh[2]);
      end
      vau_pkg::OP_CROSS: begin
        st[0] = vau_pkg::sat32(sh[0] - sh[1]);
        st[1] = vau_pkg::sat32(sh[2] - sh[3]);
        st[2] = vau_pkg::sat32(sh[4] - sh[5]);
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) s2_nxt.v[i] = st[i].val;
    s2_nxt.sc  = sd.val;
    s2_nxt.ovf = st[0].ovf | st[1].ovf | st[2].ovf | sd.ovf;
    if (op_r == vau_pkg::OP_LEN || op_r == vau_pkg::OP_NORM) begin
      s2_nxt.v   = a_r;
      s2_nxt.rad = $unsigned(p_r[0]) + $unsigned(p_r[1]) + $unsigned(p_r[2]);
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_data  = s2_r;

endmodule

[hw/rtl/vau_sqrt_step.sv]
// ----------------------------------------------------------------------------
// vau_sqrt_step
// One registered digit of the restoring integer square root.
// ----------------------------------------------------------------------------
module vau_sqrt_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  vau_pkg::vau_sq_t in_data,
  output logic             out_valid,
  output vau_pkg::vau_sq_t out_data
);

  logic             v_r;
  vau_pkg::vau_sq_t d_r;
  vau_pkg::vau_sq_t d_nxt;
  logic [35:0]      rem2;
  logic [35:0]      trial;
  logic [35:0]      diff;
  logic             ge;

  // Bring down two radicand bits, try root*4+1
  always_comb begin
    rem2       = {in_data.rem, in_data.rad[63:62]};
    trial      = {2'b00, in_data.root, 2'b01};
    ge         = rem2 >= trial;
    diff       = rem2 - trial;
    d_nxt      = in_data;
    d_nxt.rad  = {in_data.rad[61:0], 2'b00};
    d_nxt.rem  = ge ? diff[33:0] : rem2[33:0];
    d_nxt.root = {in_data.root[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

[hw/rtl/vau_div_step.sv]
// ----------------------------------------------------------------------------
// vau_div_step
// One registered quotient bit of the three normalize divides.
// ----------------------------------------------------------------------------
module vau_div_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  vau_pkg::vau_dv_t in_data,
  output logic             out_valid,
  output vau_pkg::vau_dv_t out_data
);

  logic             v_r;
  vau_pkg::vau_dv_t d_r;
  vau_pkg::vau_dv_t d_nxt;
  logic [33:0]      den;
  logic [33:0]      diff [3];
  logic [2:0]       ge;

  // Compare, subtract, shift for each lane
  always_comb begin
    den   = {2'b00, in_data.len};
    d_nxt = in_data;
    for (int i = 0; i < 3; i++) begin
      ge[i]        = in_data.rem[i] >= den;
      diff[i]      = ge[i] ? (in_data.rem[i] - den) : in_data.rem[i];
      d_nxt.rem[i] = {diff[i][32:0], 1'b0};
      d_nxt.quo[i] = {in_data.quo[i][vau_pkg::QUO_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

[hw/rtl/vau_checker.sv]
// ----------------------------------------------------------------------------
// vau_checker
// Port-level checks for the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "vec3_arithmetic_unit_defines.svh"

module vau_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input vau_pkg::vau_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input vau_pkg::vau_out_t out_data
);

  logic sat_seen;

  assign sat_seen = out_data.r_x == 32'h7FFF_FFFF || out_data.r_x == 32'h8000_0000 ||
                    out_data.r_y == 32'h7FFF_FFFF || out_data.r_y == 32'h8000_0000 ||
                    out_data.r_z == 32'h7FFF_FFFF || out_data.r_z == 32'h8000_0000 ||
                    out_data.scalar_out == 32'h7FFF_FFFF ||
                    out_data.scalar_out == 32'h8000_0000;

  // A waiting result stops intake
  `VAU_ASSERT(a_stall_blocks_input, clk, rst_n, (out_valid && !out_ready) |-> !in_ready)
  // A waiting result holds
  `VAU_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
  // Overflow only with a clamped value
  `VAU_ASSERT(a_ovf_saturated, clk, rst_n, (out_valid && out_data.overflow) |-> sat_seen)
  // Reset empties the pipe
  `VAU_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind vec3_arithmetic_unit vau_checker u_vau_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
